// ===== hw/rtl/pts_pkg.sv =====
// Package for the periodic task scheduler: shared codes, types and constants.
// No dependencies; used by every module of the block.
package pts_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned RAW_W       = 16;
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned CNT_W       = 4;   // holds 0..MAX_RESULTS
  localparam int unsigned FIDX_W      = 3;

  localparam logic [DATA_W-1:0] DUE_LIMIT = 32'h7FFF_FFFF;
  localparam logic [RAW_W-1:0]  TPM_RESET = 16'd125;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_SET     = 2'd1,
    ACT_ENABLE  = 2'd2,
    ACT_DISABLE = 2'd3
  } pts_action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMD,
    ST_DIFF,
    ST_DIV,
    ST_RAW,
    ST_CLK,
    ST_CHK,
    ST_ADV,
    ST_FINISH
  } pts_state_e;

  // Table access request from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_period;
    logic wr_due;
    logic set_on;
    logic clr_on;
  } pts_tbl_req_t;

endpackage

// ===== hw/rtl/periodic_task_scheduler_core.sv =====
// Periodic task scheduler. Set, enable and disable items give one result.
// A tick item runs the elapsed time through a restoring divider on the one
// shared adder, updates the clock, then walks the task table one slot at a
// time, advancing the due time of each fired slot; a tick with less than one
// millisecond elapsed or with a zero divider ends without the walk. The
// output side can stall the sequencer by holding ready low. The next item is
// taken once the sequencer is back in idle; the last result may still wait in
// the output register then. Fired results come one per due task in index
// order, at most 8 per tick. Depends on pts_pkg, pts_alu, pts_task_table.
module periodic_task_scheduler_core
  import pts_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [RAW_W-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          action_i,
  input  logic [7:0]          task_index_i,
  input  logic [DATA_W-1:0]   interval_ms_i,
  input  logic [RAW_W-1:0]    raw_count_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [FIDX_W-1:0]   fired_index_o,
  output logic                fired_o,
  output logic                accepted_o,
  output logic                last_o,
  output logic [DATA_W-1:0]   now_ms_o
);

  localparam int unsigned IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [7:0]    SLOTS8    = 8'(TASK_SLOTS);
  localparam logic [IW-1:0] LAST_SLOT = IW'(TASK_SLOTS - 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RESULTS);

  pts_state_e state_q, state_d;

  // item registers
  pts_action_e       act_q;
  logic [IW-1:0]     idx_q;
  logic              ok_q;
  logic [DATA_W-1:0] interval_q;
  logic [RAW_W-1:0]  raw_q;

  // architectural state
  logic [RAW_W-1:0]  tpm_q, raw_prev_q;
  logic [DATA_W-1:0] millis_q;

  // divider and walk
  logic [RAW_W-1:0]  dividend_q, rem_q, quot_q;
  logic [3:0]        cnt_q;
  logic [IW-1:0]     slot_q;
  logic [CNT_W-1:0]  n_q;
  logic              pend_q;
  logic [FIDX_W-1:0] pend_idx_q;

  // output register
  logic              out_valid_q;
  logic [FIDX_W-1:0] out_idx_q;
  logic              out_fired_q, out_acc_q, out_last_q;
  logic [DATA_W-1:0] out_now_q;

  logic              in_acc, in_ok, can_load;
  logic [DATA_W-1:0] alu_a, alu_b;
  logic              alu_sub;
  logic [DATA_W:0]   alu_res;
  pts_tbl_req_t      tbl_req;
  logic [IW-1:0]     rd_addr, wr_addr;
  logic [DATA_W-1:0] rd_period, rd_due;
  logic              rd_on;
  logic              fire, div_ge, emit_pend, adv_stall, n_room;
  logic              out_load, out_fired_d, out_acc_d, out_last_d;
  logic [FIDX_W-1:0] out_idx_d;
  logic [IW+FIDX_W-1:0] slot_ext;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_ok      = (task_index_i < SLOTS8);
  assign can_load   = !out_valid_q || out_ready_i;

  assign fire     = rd_on && !alu_res[DATA_W-1] && (alu_res[DATA_W-1:0] != DUE_LIMIT);
  assign div_ge   = !alu_res[DATA_W];
  assign n_room   = (n_q < MAX_CNT);
  assign emit_pend = n_room && pend_q;
  assign adv_stall = emit_pend && !can_load;
  assign slot_ext  = {{FIDX_W{1'b0}}, slot_q};

  pts_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .res_o (alu_res)
  );

  pts_task_table #(
    .TASK_SLOTS (TASK_SLOTS),
    .IW         (IW)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (tbl_req),
    .rd_addr_i   (rd_addr),
    .wr_addr_i   (wr_addr),
    .wr_period_i (interval_q),
    .wr_due_i    (alu_res[DATA_W-1:0]),
    .rd_period_o (rd_period),
    .rd_due_o    (rd_due),
    .rd_on_o     (rd_on)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (pts_action_e'(action_i) == ACT_TICK) ? ST_DIFF : ST_CMD;
        end
      end
      ST_CMD:    if (can_load) state_d = ST_IDLE;
      ST_DIFF:   state_d = (tpm_q == '0) ? ST_FINISH : ST_DIV;
      ST_DIV:    if (cnt_q == '0) state_d = ST_RAW;
      ST_RAW:    state_d = (quot_q == '0) ? ST_FINISH : ST_CLK;
      ST_CLK:    state_d = ST_CHK;
      ST_CHK: begin
        if (fire)                     state_d = ST_ADV;
        else if (slot_q == LAST_SLOT) state_d = ST_FINISH;
      end
      ST_ADV: begin
        if (!adv_stall) state_d = (slot_q == LAST_SLOT) ? ST_FINISH : ST_CHK;
      end
      ST_FINISH: if (can_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    alu_a       = '0;
    alu_b       = '0;
    alu_sub     = 1'b0;
    tbl_req     = '0;
    rd_addr     = slot_q;
    wr_addr     = slot_q;
    out_load    = 1'b0;
    out_idx_d   = '0;
    out_fired_d = 1'b0;
    out_acc_d   = 1'b1;
    out_last_d  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        rd_addr       = task_index_i[IW-1:0];
        tbl_req.rd_en = in_acc && in_ok && (pts_action_e'(action_i) != ACT_TICK);
      end
      ST_CMD: begin
        alu_a   = millis_q;
        alu_b   = (act_q == ACT_SET) ? interval_q : rd_period;
        wr_addr = idx_q;
        if (can_load) begin
          out_load  = 1'b1;
          out_acc_d = ok_q;
          if (ok_q) begin
            case (act_q)
              ACT_SET: begin
                tbl_req.wr_period = 1'b1;
                tbl_req.wr_due    = 1'b1;
              end
              ACT_ENABLE: begin
                tbl_req.wr_due = 1'b1;
                tbl_req.set_on = 1'b1;
              end
              ACT_DISABLE: tbl_req.clr_on = 1'b1;
              default: ;
            endcase
          end
        end
      end
      ST_DIFF: begin
        alu_a   = {16'b0, raw_q};
        alu_b   = {16'b0, raw_prev_q};
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = {15'b0, rem_q, dividend_q[RAW_W-1]};
        alu_b   = {16'b0, tpm_q};
        alu_sub = 1'b1;
      end
      ST_RAW: begin
        alu_a   = {16'b0, raw_q};
        alu_b   = {16'b0, rem_q};
        alu_sub = 1'b1;
      end
      ST_CLK: begin
        alu_a         = millis_q;
        alu_b         = {16'b0, quot_q};
        rd_addr       = '0;
        tbl_req.rd_en = 1'b1;
      end
      ST_CHK: begin
        alu_a   = millis_q;
        alu_b   = rd_due;
        alu_sub = 1'b1;
        rd_addr = slot_q + 1'b1;
        tbl_req.rd_en = !fire && (slot_q != LAST_SLOT);
      end
      ST_ADV: begin
        alu_a   = rd_due;
        alu_b   = rd_period;
        rd_addr = slot_q + 1'b1;
        if (!adv_stall) begin
          tbl_req.wr_due = 1'b1;
          tbl_req.rd_en  = (slot_q != LAST_SLOT);
          out_load       = emit_pend;
          out_idx_d      = pend_idx_q;
          out_fired_d    = 1'b1;
          out_last_d     = 1'b0;
        end
      end
      ST_FINISH: begin
        out_load    = can_load;
        out_idx_d   = pend_q ? pend_idx_q : '0;
        out_fired_d = pend_q;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tpm_q       <= TPM_RESET;
      raw_prev_q  <= '0;
      millis_q    <= '0;
      pend_q      <= 1'b0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) tpm_q <= cfg_wdata_i;
      if (state_q == ST_RAW && quot_q != '0) raw_prev_q <= alu_res[RAW_W-1:0];
      if (state_q == ST_CLK) begin
        millis_q <= alu_res[DATA_W-1:0];
        n_q      <= '0;
      end
      if (state_q == ST_ADV && !adv_stall && n_room) begin
        pend_q <= 1'b1;
        n_q    <= n_q + 1'b1;
      end
      if (state_q == ST_FINISH && can_load) pend_q <= 1'b0;
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q      <= pts_action_e'(action_i);
      idx_q      <= task_index_i[IW-1:0];
      ok_q       <= in_ok;
      interval_q <= interval_ms_i;
      raw_q      <= raw_count_i;
    end
    if (state_q == ST_DIFF) begin
      dividend_q <= alu_res[RAW_W-1:0];
      rem_q      <= '0;
      quot_q     <= '0;
      cnt_q      <= 4'd15;
    end
    if (state_q == ST_DIV) begin
      rem_q      <= div_ge ? alu_res[RAW_W-1:0] : alu_a[RAW_W-1:0];
      quot_q     <= {quot_q[RAW_W-2:0], div_ge};
      dividend_q <= {dividend_q[RAW_W-2:0], 1'b0};
      cnt_q      <= cnt_q - 1'b1;
    end
    if (state_q == ST_CLK) slot_q <= '0;
    if (state_q == ST_CHK && !fire && slot_q != LAST_SLOT) slot_q <= slot_q + 1'b1;
    if (state_q == ST_ADV && !adv_stall) begin
      if (n_room) pend_idx_q <= slot_ext[FIDX_W-1:0];
      if (slot_q != LAST_SLOT) slot_q <= slot_q + 1'b1;
    end
    if (out_load) begin
      out_idx_q   <= out_idx_d;
      out_fired_q <= out_fired_d;
      out_acc_q   <= out_acc_d;
      out_last_q  <= out_last_d;
      out_now_q   <= millis_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign fired_index_o = out_idx_q;
  assign fired_o       = out_fired_q;
  assign accepted_o    = out_acc_q;
  assign last_o        = out_last_q;
  assign now_ms_o      = out_now_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sequencer took an item without leaving idle");

  a_fired_is_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fired_o |-> accepted_o)
    else $error("fired result not marked accepted");

  a_plain_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !fired_o |-> last_o)
    else $error("non-fired result not marked last");

  a_result_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= MAX_CNT)
    else $error("fired result count exceeds limit");
`endif

endmodule

// ===== hw/rtl/pts_alu.sv =====
// Shared 32-bit add/subtract unit of the task scheduler.
// Bit 32 of the result is the carry (add) or the borrow (subtract).
module pts_alu
  import pts_pkg::*;
(
  input  logic [DATA_W-1:0] a_i,
  input  logic [DATA_W-1:0] b_i,
  input  logic              sub_i,
  output logic [DATA_W:0]   res_o
);

  always_comb begin
    if (sub_i) begin
      res_o = {1'b0, a_i} - {1'b0, b_i};
    end else begin
      res_o = {1'b0, a_i} + {1'b0, b_i};
    end
  end

endmodule

// ===== hw/rtl/pts_task_table.sv =====
// Task table: period and due-time memories with registered read, per-entry
// written flags (unwritten entries read as zero) and the enable bits.
// Depends on pts_pkg.
module pts_task_table
  import pts_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = 8,
  parameter int unsigned IW         = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pts_tbl_req_t      req_i,
  input  logic [IW-1:0]     rd_addr_i,
  input  logic [IW-1:0]     wr_addr_i,
  input  logic [DATA_W-1:0] wr_period_i,
  input  logic [DATA_W-1:0] wr_due_i,
  output logic [DATA_W-1:0] rd_period_o,
  output logic [DATA_W-1:0] rd_due_o,
  output logic              rd_on_o
);

  logic [DATA_W-1:0]     period_mem [TASK_SLOTS];
  logic [DATA_W-1:0]     due_mem    [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] pvld_q, dvld_q, on_q;
  logic [DATA_W-1:0]     rd_period_q, rd_due_q;
  logic                  rd_pv_q, rd_dv_q, rd_on_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= '0;
      dvld_q <= '0;
      on_q   <= '0;
    end else begin
      if (req_i.wr_period) pvld_q[wr_addr_i] <= 1'b1;
      if (req_i.wr_due)    dvld_q[wr_addr_i] <= 1'b1;
      if (req_i.set_on)    on_q[wr_addr_i]   <= 1'b1;
      if (req_i.clr_on)    on_q[wr_addr_i]   <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_period) period_mem[wr_addr_i] <= wr_period_i;
    if (req_i.wr_due)    due_mem[wr_addr_i]    <= wr_due_i;
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_period_q <= period_mem[rd_addr_i];
      rd_due_q    <= due_mem[rd_addr_i];
      rd_pv_q     <= pvld_q[rd_addr_i];
      rd_dv_q     <= dvld_q[rd_addr_i];
      rd_on_q     <= on_q[rd_addr_i];
    end
  end

  assign rd_period_o = rd_pv_q ? rd_period_q : '0;
  assign rd_due_o    = rd_dv_q ? rd_due_q : '0;
  assign rd_on_o     = rd_on_q;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for periodic_task_scheduler_core: directed and random items
// go through a valid/ready driver, and every result is checked against an in-bench model.
// Depends on pts_pkg and on the core RTL.
module tb;
  import pts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = 8;

  typedef struct {
    pts_action_e       action;
    logic [7:0]        idx;
    logic [DATA_W-1:0] interval;
    logic [RAW_W-1:0]  raw;
    int unsigned       hold;
  } sched_cmd_t;

  typedef struct packed {
    logic [FIDX_W-1:0] fired_index;
    logic              fired;
    logic              accepted;
    logic              last;
    logic [DATA_W-1:0] now_ms;
  } sched_report_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [RAW_W-1:0]    cfg_wdata_i   = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  pts_action_e         action_i      = ACT_TICK;
  logic [7:0]          task_index_i  = '0;
  logic [DATA_W-1:0]   interval_ms_i = '0;
  logic [RAW_W-1:0]    raw_count_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [FIDX_W-1:0]   fired_index_o;
  logic                fired_o;
  logic                accepted_o;
  logic                last_o;
  logic [DATA_W-1:0]   now_ms_o;

  periodic_task_scheduler_core #(
    .TASK_SLOTS(SLOTS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .task_index_i (task_index_i),
    .interval_ms_i(interval_ms_i),
    .raw_count_i  (raw_count_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .fired_index_o(fired_index_o),
    .fired_o      (fired_o),
    .accepted_o   (accepted_o),
    .last_o       (last_o),
    .now_ms_o     (now_ms_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the task table, clock and tick divider
  logic [DATA_W-1:0] period_ms [SLOTS];
  logic [DATA_W-1:0] due_ms    [SLOTS];
  logic              armed     [SLOTS];
  logic [DATA_W-1:0] clock_ms;
  logic [RAW_W-1:0]  raw_last;
  logic [RAW_W-1:0]  tpm;

  sched_cmd_t    cmd_backlog[$];
  sched_report_t owed_reports[$];
  int unsigned   mismatches = 0;

  logic [RAW_W-1:0] raw_cursor;
  int unsigned      calm_left = 0;

  function automatic void run_scheduler(sched_cmd_t c);
    sched_report_t    r;
    logic [RAW_W-1:0] diff;
    logic [DATA_W-1:0] elapsed;
    logic [DATA_W-1:0] lag;
    logic [SLOTS-1:0] hit;
    int               n;
    int               k;
    r = '{fired_index: '0, fired: 1'b0, accepted: 1'b1, last: 1'b1, now_ms: '0};
    if (c.action != ACT_TICK) begin
      if (c.idx < SLOTS) begin
        case (c.action)
          ACT_SET: begin
            period_ms[c.idx] = c.interval;
            due_ms[c.idx]    = clock_ms + c.interval;
          end
          ACT_ENABLE: begin
            armed[c.idx]  = 1'b1;
            due_ms[c.idx] = clock_ms + period_ms[c.idx];
          end
          default: armed[c.idx] = 1'b0;
        endcase
      end else begin
        r.accepted = 1'b0;
      end
      r.now_ms = clock_ms;
      owed_reports.push_back(r);
      return;
    end
    hit  = '0;
    n    = 0;
    diff = c.raw - raw_last;
    elapsed = (tpm != 0) ? DATA_W'(diff / tpm) : '0;
    if (elapsed != 0) begin
      raw_last = raw_last + RAW_W'(elapsed[RAW_W-1:0] * tpm);
      clock_ms = clock_ms + elapsed;
      for (int j = 0; j < SLOTS; j++) begin
        lag = clock_ms - due_ms[j];
        if (armed[j] && lag < DUE_LIMIT) begin
          due_ms[j] = due_ms[j] + period_ms[j];
          hit[j] = 1'b1;
          n++;
        end
      end
    end
    r.now_ms = clock_ms;
    if (n == 0) begin
      owed_reports.push_back(r);
      return;
    end
    k = 0;
    for (int j = 0; j < SLOTS; j++) begin
      if (hit[j] && k < MAX_RESULTS) begin
        r.fired_index = FIDX_W'(j);
        r.fired       = 1'b1;
        r.last        = (k == n - 1 || k == MAX_RESULTS - 1);
        owed_reports.push_back(r);
        k++;
      end
    end
  endfunction

  // Driver: one item in flight, idle gap taken from the item before valid rises
  sched_cmd_t  cur;
  logic        feeding   = 1'b0;
  int unsigned wait_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      feeding = 1'b0;
      wait_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        run_scheduler(cur);
        feeding = 1'b0;
      end
      if (!feeding && cmd_backlog.size() != 0) begin
        cur = cmd_backlog.pop_front();
        wait_left = cur.hold;
        feeding = 1'b1;
        action_i      <= cur.action;
        task_index_i  <= cur.idx;
        interval_ms_i <= cur.interval;
        raw_count_i   <= cur.raw;
      end
      if (feeding && wait_left != 0) begin
        wait_left--;
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= feeding;
      end
    end
  end

  // Monitor: compare each result, then stall ready for a random count
  int unsigned stall_left = 0;
  int unsigned rx_count   = 0;
  logic        rx_calm    = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    sched_report_t got;
    sched_report_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = '{fired_index: fired_index_o, fired: fired_o, accepted: accepted_o,
                last: last_o, now_ms: now_ms_o};
        if (owed_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result idx=%0d fired=%0b acc=%0b last=%0b now=%0h",
                     $realtime, got.fired_index, got.fired, got.accepted, got.last,
                     got.now_ms);
        end else begin
          want = owed_reports.pop_front();
          if (got !== want) begin
            mismatches++;
            // fields as idx/fired/acc/last/now
            if (mismatches <= 10)
              $display("%0t: mismatch exp %0d/%0b/%0b/%0b/%0h got %0d/%0b/%0b/%0b/%0h",
                       $realtime, want.fired_index, want.fired, want.accepted,
                       want.last, want.now_ms, got.fired_index, got.fired,
                       got.accepted, got.last, got.now_ms);
          end
        end
        rx_count++;
        if (rx_count % 50 == 0) rx_calm = ($urandom_range(0, 2) == 0);
        stall_left = rx_calm ? 0 : $urandom_range(0, 5);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic void queue_cmd(pts_action_e a, logic [7:0] idx,
                                    logic [DATA_W-1:0] iv, logic [RAW_W-1:0] raw);
    sched_cmd_t c;
    int unsigned hold;
    if (calm_left != 0) begin
      calm_left--;
      hold = 0;
    end else begin
      if ($urandom_range(0, 29) == 0) calm_left = 20;
      hold = $urandom_range(0, 5);
    end
    c = '{action: a, idx: idx, interval: iv, raw: raw, hold: hold};
    cmd_backlog.push_back(c);
  endfunction

  function automatic logic [DATA_W-1:0] pick_interval();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return 32'hFFFF_FFFF;
          2: return 32'h7FFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
      default: return $urandom_range(0, 12);
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] tick_step();
    logic [DATA_W-1:0] step;
    case ($urandom_range(0, 5))
      0: step = $urandom_range(0, 65535);
      1: step = 0;
      default: begin
        step = $urandom_range(0, 3) * tpm;
        if (tpm > 1 && $urandom_range(0, 1) == 1) step = step + $urandom_range(0, tpm - 1);
      end
    endcase
    return step[RAW_W-1:0];
  endfunction

  // Mostly well-formed traffic on the eight slots, with some out-of-range noise
  task automatic queue_random(int unsigned count);
    int unsigned roll;
    logic [7:0]  idx;
    raw_cursor = raw_last;
    for (int unsigned i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        queue_cmd(pts_action_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  $urandom, 16'($urandom));
      end else if (roll < 55) begin
        raw_cursor = raw_cursor + tick_step();
        queue_cmd(ACT_TICK, 8'($urandom_range(0, 255)), $urandom, raw_cursor);
      end else begin
        idx = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, SLOTS - 1));
        if (roll < 72)
          queue_cmd(ACT_SET, idx, pick_interval(), 16'($urandom));
        else if (roll < 91)
          queue_cmd(ACT_ENABLE, idx, $urandom, 16'($urandom));
        else
          queue_cmd(ACT_DISABLE, idx, $urandom, 16'($urandom));
      end
    end
  endtask

  task automatic settle();
    while (cmd_backlog.size() != 0 || feeding || owed_reports.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_tpm(logic [RAW_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tpm = value;
  endtask

  initial begin
    for (int j = 0; j < SLOTS; j++) begin
      period_ms[j] = '0;
      due_ms[j]    = '0;
      armed[j]     = 1'b0;
    end
    clock_ms = '0;
    raw_last = '0;
    tpm      = TPM_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset divider of 125 counts per ms
    queue_cmd(ACT_SET,     8'd0,   32'd1,          '0);
    queue_cmd(ACT_SET,     8'd1,   32'd0,          '0);
    queue_cmd(ACT_SET,     8'd7,   32'hFFFF_FFFF,  16'hFFFF);
    queue_cmd(ACT_SET,     8'd8,   32'd5,          '0);
    queue_cmd(ACT_SET,     8'd255, 32'hDEAD_BEEF,  '0);
    queue_cmd(ACT_ENABLE,  8'd0,   '0,             '0);
    queue_cmd(ACT_ENABLE,  8'd1,   '0,             '0);
    queue_cmd(ACT_ENABLE,  8'd7,   '0,             '0);
    queue_cmd(ACT_ENABLE,  8'd200, '0,             '0);
    queue_cmd(ACT_TICK,    8'd0,   '0,             16'd124);  // under one ms
    queue_cmd(ACT_TICK,    8'd0,   '0,             16'd250);
    queue_cmd(ACT_SET,     8'd2,   32'h8000_0000,  '0);
    queue_cmd(ACT_ENABLE,  8'd2,   '0,             '0);
    queue_cmd(ACT_SET,     8'd3,   32'h7FFF_FFFF,  '0);
    queue_cmd(ACT_ENABLE,  8'd3,   '0,             '0);
    queue_cmd(ACT_TICK,    8'd0,   '0,             16'hFFFF);
    queue_cmd(ACT_TICK,    8'd0,   '0,             16'h0010); // raw count wraps
    queue_cmd(ACT_DISABLE, 8'd1,   '0,             '0);
    queue_cmd(ACT_DISABLE, 8'd255, '0,             '0);
    queue_cmd(ACT_TICK,    8'd0,   '0,             16'h0400);
    queue_cmd(ACT_SET,     8'd4,   32'd3,          '0);
    queue_cmd(ACT_SET,     8'd5,   32'd2,          '0);
    queue_cmd(ACT_ENABLE,  8'd4,   '0,             '0);
    queue_cmd(ACT_ENABLE,  8'd5,   '0,             '0);
    queue_cmd(ACT_TICK,    8'd0,   '0,             16'h2000);
    settle();

    write_tpm(16'd1);
    queue_random(80);
    settle();
    write_tpm(16'hFFFF);
    queue_random(40);
    settle();
    // zero divider: no time passes
    write_tpm(16'd0);
    queue_random(20);
    settle();
    write_tpm(16'($urandom_range(2, 400)));
    queue_random(100);
    settle();
    write_tpm(TPM_RESET);
    queue_random(180);
    settle();

    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && owed_reports.size() == 0) begin
      $display("PASS periodic_task_scheduler_core");
    end else begin
      $display("FAIL periodic_task_scheduler_core");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL periodic_task_scheduler_core");
    $finish;
  end

endmodule
